>>> rtl/core/sgvs_pkg.sv
// Shared definitions for the smoothing-group vertex splitter.
// Stream field layout, parameter defaults and the sequencer state type.
// No dependencies.
package sgvs_pkg;

  // Parameter defaults
  localparam int DEF_MAX_ORIGINAL_VERTICES = 1024;
  localparam int DEF_MAX_SPLITS_PER_VERTEX = 8;
  localparam int DEF_MAX_SPLIT_VERTICES    = 4096;
  localparam int DEF_GROUP_BITS            = 64;

  // Input word fields
  localparam int FACE_W  = 16;
  localparam int GROUP_W = 64;
  localparam int VTX_W   = 10;
  localparam int IN_FACE_LSB  = 0;
  localparam int IN_GROUP_LSB = IN_FACE_LSB + FACE_W;
  localparam int IN_VTX_LSB   = IN_GROUP_LSB + GROUP_W;
  localparam int IN_BITS      = IN_VTX_LSB + VTX_W;
  localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

  // Output word fields
  localparam int SPLIT_W = 12;
  localparam int OUT_FACE_LSB  = 0;
  localparam int OUT_SPLIT_LSB = OUT_FACE_LSB + FACE_W;
  localparam int OUT_SRC_LSB   = OUT_SPLIT_LSB + SPLIT_W;
  localparam int OUT_BITS      = OUT_SRC_LSB + VTX_W;
  localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

  // Output tuser flags
  localparam int USER_CREATED  = 0;
  localparam int USER_OVERFLOW = 1;
  localparam int OUT_USER_W    = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_LIST,
    ST_CHECK,
    ST_DONE
  } sgvs_state_t;

endpackage

>>> rtl/core/sgvs_vtx_table.sv
// Per-vertex table: group union and split count for each original vertex.
// Single write port, registered read, zero sweep after reset. Uses sgvs_pkg.
module sgvs_vtx_table #(
  parameter int MAX_ORIGINAL_VERTICES = sgvs_pkg::DEF_MAX_ORIGINAL_VERTICES,
  parameter int MAX_SPLITS_PER_VERTEX = sgvs_pkg::DEF_MAX_SPLITS_PER_VERTEX,
  parameter int GROUP_BITS            = sgvs_pkg::DEF_GROUP_BITS,
  localparam int VA_W  = (MAX_ORIGINAL_VERTICES > 1) ? $clog2(MAX_ORIGINAL_VERTICES) : 1,
  localparam int CNT_W = $clog2(MAX_SPLITS_PER_VERTEX + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [VA_W-1:0]       rd_addr,
  input  logic                  wr_en,
  input  logic [VA_W-1:0]       wr_addr,
  input  logic [GROUP_BITS-1:0] wr_union,
  input  logic [CNT_W-1:0]      wr_count,
  output logic [GROUP_BITS-1:0] rd_union,
  output logic [CNT_W-1:0]      rd_count,
  output logic                  busy
);
  import sgvs_pkg::*;

  localparam int WORD_W = CNT_W + GROUP_BITS;

  logic [WORD_W-1:0] mem [MAX_ORIGINAL_VERTICES];
  logic [WORD_W-1:0] rd_word_r;

  logic              clr_busy_r, clr_busy_nxt;
  logic [VA_W-1:0]   clr_addr_r, clr_addr_nxt;

  logic              mem_we;
  logic [VA_W-1:0]   mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == VA_W'(MAX_ORIGINAL_VERTICES - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end else begin
      mem_we    = wr_en;
      mem_waddr = wr_addr;
      mem_wdata = {wr_count, wr_union};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  assign rd_union = rd_word_r[GROUP_BITS-1:0];
  assign rd_count = rd_word_r[WORD_W-1:GROUP_BITS];
  assign busy     = clr_busy_r;

endmodule

>>> rtl/core/smoothing_group_vertex_splitter_unit.sv
// Top level of the smoothing-group vertex splitter: sequencer, split list
// and split mask stores, result register. Uses sgvs_pkg and sgvs_vtx_table.
//
// One input word is one face corner (face index, 64-bit smoothing-group mask,
// original vertex). Each corner yields one result word: the split vertex it
// maps to, created=1 when a new split was allocated (also for an all-zero
// mask), or overflow=1 with split 0 and no state change when the vertex is out
// of range, its split list is full or the split vertex table is full. After
// reset a sweep zeroes all MAX_ORIGINAL_VERTICES entries of the per-vertex
// table with in_tready low. A corner that allocates or overflows passes from
// acceptance through ST_DECIDE and ST_DONE to the next acceptance; a corner
// that reuses a split of its vertex also walks its split list up to that
// split: one split list read (ST_LIST), then one split mask read into the
// shared overlap check (ST_CHECK), per visited split. The result sits in an
// output register, so in_tready is not held off by a waiting result until
// the next result is ready to go out.
module smoothing_group_vertex_splitter_unit #(
  parameter int MAX_ORIGINAL_VERTICES = sgvs_pkg::DEF_MAX_ORIGINAL_VERTICES,
  parameter int MAX_SPLITS_PER_VERTEX = sgvs_pkg::DEF_MAX_SPLITS_PER_VERTEX,
  parameter int MAX_SPLIT_VERTICES    = sgvs_pkg::DEF_MAX_SPLIT_VERTICES,
  parameter int GROUP_BITS            = sgvs_pkg::DEF_GROUP_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata, low bit up: face_index[15:0], face_groups[79:16],
  // original_vertex[89:80], zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sgvs_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata, low bit up: face_tag[15:0], split_vertex[27:16],
  // source_vertex[37:28], zero pad
  // out_tuser, low bit up: created[0], overflow[1]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sgvs_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [sgvs_pkg::OUT_USER_W-1:0] out_tuser
);
  import sgvs_pkg::*;

  localparam int VA_W  = (MAX_ORIGINAL_VERTICES > 1) ? $clog2(MAX_ORIGINAL_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_SPLITS_PER_VERTEX + 1);
  localparam int SI_W  = (MAX_SPLIT_VERTICES > 1) ? $clog2(MAX_SPLIT_VERTICES) : 1;
  localparam int ST_W  = $clog2(MAX_SPLIT_VERTICES + 1);
  localparam int LIST_DEPTH = MAX_ORIGINAL_VERTICES * MAX_SPLITS_PER_VERTEX;
  localparam int LA_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // Split stores: list of split indices per vertex, accumulated mask per split
  logic [SI_W-1:0]       list_mem [LIST_DEPTH];
  logic [GROUP_BITS-1:0] smask_mem [MAX_SPLIT_VERTICES];
  logic [SI_W-1:0]       list_rd_r;
  logic [GROUP_BITS-1:0] smask_rd_r;

  // Sequencer and item registers
  sgvs_state_t           state_r, state_nxt;
  logic [FACE_W-1:0]     face_r, face_nxt;
  logic [GROUP_BITS-1:0] mask_r, mask_nxt;
  logic [VTX_W-1:0]      vtx_r, vtx_nxt;
  logic [VA_W-1:0]       vaddr_r, vaddr_nxt;
  logic                  oor_r, oor_nxt;
  logic [LA_W-1:0]       base_r, base_nxt;
  logic [CNT_W-1:0]      scan_r, scan_nxt;
  logic [SI_W-1:0]       cur_idx_r, cur_idx_nxt;
  logic [ST_W-1:0]       total_r, total_nxt;

  // Result and output registers
  logic [SPLIT_W-1:0]    res_split_r, res_split_nxt;
  logic                  res_created_r, res_created_nxt;
  logic                  res_ovf_r, res_ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  // Vertex table port
  logic                  vt_rd_en;
  logic                  vt_wr_en;
  logic [GROUP_BITS-1:0] vt_wr_union;
  logic [CNT_W-1:0]      vt_wr_count;
  logic [GROUP_BITS-1:0] vt_union;
  logic [CNT_W-1:0]      vt_count;
  logic                  vt_busy;

  // Split store ports
  logic                  list_rd_en;
  logic [LA_W-1:0]       list_rd_addr;
  logic                  list_wr_en;
  logic [LA_W-1:0]       list_wr_addr;
  logic                  smask_rd_en;
  logic                  smask_wr_en;
  logic [SI_W-1:0]       smask_wr_addr;
  logic [GROUP_BITS-1:0] smask_wr_data;

  // Shared overlap unit: OR-reduce of the corner mask ANDed with one operand
  logic [GROUP_BITS-1:0] ovl_op;
  logic                  overlap;

  logic [31:0]           in_vtx_wide;
  logic [31:0]           base_wide;
  logic [31:0]           total_idx_wide;
  logic [31:0]           cur_idx_wide;
  logic [SI_W-1:0]       total_idx;
  logic                  in_fire;
  logic                  out_free;
  logic                  list_full;
  logic                  table_full;
  logic                  idx_ok;
  logic [CNT_W-1:0]      scan_next;

  sgvs_vtx_table #(
    .MAX_ORIGINAL_VERTICES (MAX_ORIGINAL_VERTICES),
    .MAX_SPLITS_PER_VERTEX (MAX_SPLITS_PER_VERTEX),
    .GROUP_BITS            (GROUP_BITS)
  ) u_vtx_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (vt_rd_en),
    .rd_addr  (vaddr_nxt),
    .wr_en    (vt_wr_en),
    .wr_addr  (vaddr_r),
    .wr_union (vt_wr_union),
    .wr_count (vt_wr_count),
    .rd_union (vt_union),
    .rd_count (vt_count),
    .busy     (vt_busy)
  );

  assign in_tready = (state_r == ST_IDLE) && !vt_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign in_vtx_wide    = 32'(in_tdata[IN_VTX_LSB +: VTX_W]);
  assign base_wide      = in_vtx_wide * 32'(MAX_SPLITS_PER_VERTEX);
  assign total_idx      = total_r[SI_W-1:0];
  assign total_idx_wide = 32'(total_idx);
  assign cur_idx_wide   = 32'(cur_idx_r);

  assign overlap    = |(mask_r & ovl_op);
  assign list_full  = vt_count >= CNT_W'(MAX_SPLITS_PER_VERTEX);
  assign table_full = total_r >= ST_W'(MAX_SPLIT_VERTICES);
  // index guard for non power-of-two split tables
  assign idx_ok     = 32'(cur_idx_r) < 32'(MAX_SPLIT_VERTICES);
  assign scan_next  = scan_r + 1'b1;

  always_comb begin
    state_nxt       = state_r;
    face_nxt        = face_r;
    mask_nxt        = mask_r;
    vtx_nxt         = vtx_r;
    vaddr_nxt       = vaddr_r;
    oor_nxt         = oor_r;
    base_nxt        = base_r;
    scan_nxt        = scan_r;
    cur_idx_nxt     = cur_idx_r;
    total_nxt       = total_r;
    res_split_nxt   = res_split_r;
    res_created_nxt = res_created_r;
    res_ovf_nxt     = res_ovf_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    out_user_nxt    = out_user_r;

    vt_rd_en      = 1'b0;
    vt_wr_en      = 1'b0;
    vt_wr_union   = vt_union | mask_r;
    vt_wr_count   = vt_count;
    list_rd_en    = 1'b0;
    list_rd_addr  = base_r + LA_W'(scan_r);
    list_wr_en    = 1'b0;
    list_wr_addr  = base_r + LA_W'(vt_count);
    smask_rd_en   = 1'b0;
    smask_wr_en   = 1'b0;
    smask_wr_addr = total_idx;
    smask_wr_data = mask_r;
    ovl_op        = vt_union;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          face_nxt  = in_tdata[IN_FACE_LSB +: FACE_W];
          mask_nxt  = in_tdata[IN_GROUP_LSB +: GROUP_BITS];
          vtx_nxt   = in_tdata[IN_VTX_LSB +: VTX_W];
          vaddr_nxt = in_vtx_wide[VA_W-1:0];
          oor_nxt   = in_vtx_wide >= 32'(MAX_ORIGINAL_VERTICES);
          base_nxt  = base_wide[LA_W-1:0];
          vt_rd_en  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        res_split_nxt   = '0;
        res_created_nxt = 1'b0;
        res_ovf_nxt     = 1'b0;
        state_nxt       = ST_DONE;
        if (oor_r) begin
          res_ovf_nxt = 1'b1;
        end else if (!overlap) begin
          if (list_full || table_full) begin
            res_ovf_nxt = 1'b1;
          end else begin
            // allocate a new split at the end of the table
            vt_wr_en        = 1'b1;
            vt_wr_count     = vt_count + 1'b1;
            list_wr_en      = 1'b1;
            smask_wr_en     = 1'b1;
            total_nxt       = total_r + 1'b1;
            res_split_nxt   = total_idx_wide[SPLIT_W-1:0];
            res_created_nxt = 1'b1;
          end
        end else if (vt_count != '0) begin
          // walk the vertex's split list from the first entry
          scan_nxt     = '0;
          list_rd_en   = 1'b1;
          list_rd_addr = base_r;
          state_nxt    = ST_LIST;
        end
      end

      ST_LIST: begin
        cur_idx_nxt = list_rd_r;
        smask_rd_en = 1'b1;
        state_nxt   = ST_CHECK;
      end

      ST_CHECK: begin
        ovl_op = smask_rd_r;
        if (idx_ok && overlap) begin
          smask_wr_en     = 1'b1;
          smask_wr_addr   = cur_idx_r;
          smask_wr_data   = smask_rd_r | mask_r;
          vt_wr_en        = 1'b1;
          res_split_nxt   = cur_idx_wide[SPLIT_W-1:0];
          state_nxt       = ST_DONE;
        end else if (scan_next < vt_count) begin
          scan_nxt     = scan_next;
          list_rd_en   = 1'b1;
          list_rd_addr = base_r + LA_W'(scan_next);
          state_nxt    = ST_LIST;
        end else begin
          // no overlapping split: plain zero result, nothing written
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[OUT_FACE_LSB +: FACE_W]   = face_r;
          out_data_nxt[OUT_SPLIT_LSB +: SPLIT_W] = res_split_r;
          out_data_nxt[OUT_SRC_LSB +: VTX_W]     = vtx_r;
          out_user_nxt[USER_CREATED]  = res_created_r;
          out_user_nxt[USER_OVERFLOW] = res_ovf_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    face_r        <= face_nxt;
    mask_r        <= mask_nxt;
    vtx_r         <= vtx_nxt;
    vaddr_r       <= vaddr_nxt;
    oor_r         <= oor_nxt;
    base_r        <= base_nxt;
    scan_r        <= scan_nxt;
    cur_idx_r     <= cur_idx_nxt;
    res_split_r   <= res_split_nxt;
    res_created_r <= res_created_nxt;
    res_ovf_r     <= res_ovf_nxt;
    out_data_r    <= out_data_nxt;
    out_user_r    <= out_user_nxt;
  end

  // split list store
  always_ff @(posedge clk) begin
    if (list_wr_en) begin
      list_mem[list_wr_addr] <= total_idx;
    end
    if (list_rd_en) begin
      list_rd_r <= list_mem[list_rd_addr];
    end
  end

  // split mask store
  always_ff @(posedge clk) begin
    if (smask_wr_en) begin
      smask_mem[smask_wr_addr] <= smask_wr_data;
    end
    if (smask_rd_en) begin
      smask_rd_r <= smask_mem[list_rd_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> rtl/core/sgvs_checker.sv
// Port-level checks for the smoothing-group vertex splitter, bound to the top.
// Uses sgvs_pkg; attaches to smoothing_group_vertex_splitter_unit.
module sgvs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sgvs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [sgvs_pkg::OUT_USER_W-1:0] out_tuser
);
  import sgvs_pkg::*;

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // one corner at a time: no acceptance right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while busy");

  // table sweep keeps input closed coming out of reset
  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during table sweep");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[USER_CREATED] && out_tuser[USER_OVERFLOW]))
    else $error("created and overflow both set");

  a_overflow_zero_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_OVERFLOW] |-> out_tdata[OUT_SPLIT_LSB +: SPLIT_W] == '0)
    else $error("overflow result carries a split index");

endmodule

bind smoothing_group_vertex_splitter_unit sgvs_checker u_sgvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
